@@ hw/rtl/s20_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and functions for the Salsa20 stream cipher.
// No dependencies; used by s20_core and salsa20_stream_cipher.
package s20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNTER = 3'd5;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [15:0][31:0] t_words;

    typedef struct packed {
        logic [63:0] key_low;
        logic [63:0] key_mid_low;
        logic [63:0] key_mid_high;
        logic [63:0] key_high;
        logic [63:0] nonce;
    } t_key_cfg;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        rotl32 = (x << n) | (x >> (32 - n));
    endfunction

    // One quarter round; result packed as {a, b, c, d}.
    function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wc;
        logic [31:0] wd;
        wb = b ^ rotl32(a + d, 7);
        wc = c ^ rotl32(wb + a, 9);
        wd = d ^ rotl32(wc + wb, 13);
        wa = a ^ rotl32(wd + wc, 18);
        qround = {wa, wb, wc, wd};
    endfunction

    // Initial block state from the key, nonce and block counter.
    function automatic t_words build_state(input t_key_cfg k, input logic [63:0] count);
        t_words s;
        s[0]  = SIGMA0;
        s[1]  = k.key_low[31:0];
        s[2]  = k.key_low[63:32];
        s[3]  = k.key_mid_low[31:0];
        s[4]  = k.key_mid_low[63:32];
        s[5]  = SIGMA1;
        s[6]  = k.nonce[31:0];
        s[7]  = k.nonce[63:32];
        s[8]  = count[31:0];
        s[9]  = count[63:32];
        s[10] = SIGMA2;
        s[11] = k.key_mid_high[31:0];
        s[12] = k.key_mid_high[63:32];
        s[13] = k.key_high[31:0];
        s[14] = k.key_high[63:32];
        s[15] = SIGMA3;
        build_state = s;
    endfunction

endpackage

@@ hw/rtl/s20_fifo.sv @@
`timescale 1ns / 1ps
// Small synchronous word queue used on the input and result sides.
// No dependencies.
module s20_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/s20_core.sv @@
`timescale 1ns / 1ps
// Back end: configuration registers, block generator and keystream XOR.
// Depends on s20_pkg.
module s20_core #(
    parameter int DOUBLE_ROUNDS = s20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [s20_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    input  logic                           i_in_empty,
    input  logic [8:0]                     i_in_item,
    output logic                           o_in_pop,
    input  logic                           i_out_full,
    output logic                           o_out_push,
    output logic [7:0]                     o_out_byte
);
    import s20_pkg::*;

    localparam int DR_W = $clog2(DOUBLE_ROUNDS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    t_key_cfg     r_cfg;
    logic [63:0]  r_init_counter;
    logic [1:0]   r_state, n_state;
    t_words       r_words, n_words;
    logic [63:0]  r_count, n_count;
    logic [5:0]   r_pos, n_pos;
    logic [2:0]   r_qr, n_qr;
    logic [DR_W-1:0] r_dr, n_dr;
    logic [7:0]   r_data, n_data;
    logic [63:0]  eff_count;
    logic [5:0]   eff_pos;
    t_words       init_words;
    logic [31:0]  ks_word;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg          <= '0;
            r_init_counter <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:      r_cfg.key_low      <= i_cfg_data;
                REG_KEY_MID_LOW:  r_cfg.key_mid_low  <= i_cfg_data;
                REG_KEY_MID_HIGH: r_cfg.key_mid_high <= i_cfg_data;
                REG_KEY_HIGH:     r_cfg.key_high     <= i_cfg_data;
                REG_NONCE:        r_cfg.nonce        <= i_cfg_data;
                REG_INIT_COUNTER: r_init_counter     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Item classification: a message start reloads the counter and position.
    assign eff_count  = i_in_item[0] ? r_init_counter : r_count;
    assign eff_pos    = i_in_item[0] ? 6'd0 : r_pos;
    assign init_words = build_state(r_cfg, i_in_item[0] && r_state == ST_IDLE ?
                                    eff_count : r_count);
    assign ks_word    = r_words[r_pos[5:2]];
    assign o_out_byte = r_data ^ ks_word[{r_pos[1:0], 3'b000} +: 8];

    // Sequencer: one quarter round per cycle, then the feed-forward add.
    always_comb begin
        n_state    = r_state;
        n_words    = r_words;
        n_count    = r_count;
        n_pos      = r_pos;
        n_qr       = r_qr;
        n_dr       = r_dr;
        n_data     = r_data;
        o_in_pop   = 1'b0;
        o_out_push = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_in_empty && !i_out_full) begin
                    o_in_pop = 1'b1;
                    n_data   = i_in_item[8:1];
                    n_count  = eff_count;
                    n_pos    = eff_pos;
                    if (eff_pos == 6'd0) begin
                        n_words = init_words;
                        n_qr    = '0;
                        n_dr    = '0;
                        n_state = ST_ROUND;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_ROUND: begin
                case (r_qr)
                    3'd0: {n_words[0], n_words[4], n_words[8], n_words[12]} =
                        qround(r_words[0], r_words[4], r_words[8], r_words[12]);
                    3'd1: {n_words[5], n_words[9], n_words[13], n_words[1]} =
                        qround(r_words[5], r_words[9], r_words[13], r_words[1]);
                    3'd2: {n_words[10], n_words[14], n_words[2], n_words[6]} =
                        qround(r_words[10], r_words[14], r_words[2], r_words[6]);
                    3'd3: {n_words[15], n_words[3], n_words[7], n_words[11]} =
                        qround(r_words[15], r_words[3], r_words[7], r_words[11]);
                    3'd4: {n_words[0], n_words[1], n_words[2], n_words[3]} =
                        qround(r_words[0], r_words[1], r_words[2], r_words[3]);
                    3'd5: {n_words[5], n_words[6], n_words[7], n_words[4]} =
                        qround(r_words[5], r_words[6], r_words[7], r_words[4]);
                    3'd6: {n_words[10], n_words[11], n_words[8], n_words[9]} =
                        qround(r_words[10], r_words[11], r_words[8], r_words[9]);
                    default: {n_words[15], n_words[12], n_words[13], n_words[14]} =
                        qround(r_words[15], r_words[12], r_words[13], r_words[14]);
                endcase
                n_qr = r_qr + 3'd1;
                if (r_qr == 3'd7) begin
                    if (r_dr == DR_W'(DOUBLE_ROUNDS - 1)) begin
                        n_state = ST_FINAL;
                    end else begin
                        n_dr = r_dr + 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 16; i++) begin
                    n_words[i] = r_words[i] + init_words[i];
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_push = 1'b1;
                n_pos      = r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    n_count = r_count + 64'd1;
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer and keystream state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_words <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_qr    <= '0;
            r_dr    <= '0;
        end else begin
            r_state <= n_state;
            r_words <= n_words;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_qr    <= n_qr;
            r_dr    <= n_dr;
        end
    end

    // Held data byte.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROUND |-> r_dr < DR_W'(DOUBLE_ROUNDS))
        else $error("double round count out of range");
    a_push_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> r_state == ST_EMIT)
        else $error("result word pushed outside emit");
    a_final_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINAL |=> r_state == ST_EMIT)
        else $error("final add not followed by emit");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_pop |-> r_state == ST_IDLE && !i_out_full)
        else $error("input word taken while busy");

endmodule

@@ hw/rtl/salsa20_stream_cipher.sv @@
`timescale 1ns / 1ps
// Top level of the Salsa20/20 byte stream cipher.
// Depends on s20_pkg, s20_fifo and s20_core.
//
// Channel   Direction  Handshake             Payload
// input     in         i_push / o_full       i_data_byte, i_message_start
// result    out        o_empty / i_pop       o_result_byte
// config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// In the core, a byte that needs no new block goes from idle straight to
// emit. A byte at position zero first generates a block: 8 * DOUBLE_ROUNDS
// quarter rounds, one at a time, then the feed-forward add.
// Synchronous active-low reset clears the queues and the counter.
// A four-word input queue and a two-word result queue let either side stall.
module salsa20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = s20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_message_start,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [7:0]                     o_result_byte,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [s20_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    logic       in_empty;
    logic       in_pop;
    logic [8:0] in_item;
    logic       out_full;
    logic       out_push;
    logic [7:0] out_byte;

    // Front end: input word queue.
    s20_fifo #(.WIDTH(9), .DEPTH(4)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata ({i_data_byte, i_message_start}),
        .o_full  (o_full),
        .i_pop   (in_pop),
        .o_rdata (in_item),
        .o_empty (in_empty)
    );

    // Back end: block generator and XOR.
    s20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_empty  (in_empty),
        .i_in_item   (in_item),
        .o_in_pop    (in_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_byte  (out_byte)
    );

    // Result word queue.
    s20_fifo #(.WIDTH(8), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_byte),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_rdata (o_result_byte),
        .o_empty (o_empty)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench for salsa20_stream_cipher: drives data bytes through the queue interface,
// predicts every result byte with its own Salsa20/20 keystream generator and checks them.
// Depends on s20_pkg for the register indexes, sigma constants and the index width.
module tb;
    import s20_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int PAIRS = 10;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD = 400;
    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_byte_in;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_push = 1'b0;
    logic                 o_full;
    logic [7:0]           i_data_byte = '0;
    logic                 i_message_start = 1'b0;
    logic                 o_empty;
    logic                 i_pop = 1'b0;
    logic [7:0]           o_result_byte;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;

    salsa20_stream_cipher #(.DOUBLE_ROUNDS(PAIRS)) dut (.*);

    always #CLK_HALF i_clk = ~i_clk;

    // Predictor state: register copies, block counter, position and current keystream block.
    logic [63:0] key_regs [6];
    logic [63:0] next_block_count;
    logic [5:0]  stream_pos;
    logic [7:0]  keystream [64];
    logic [31:0] mix_words [16];

    t_byte_in   pending_bytes [$];
    logic [7:0] expected_bytes [$];
    int         mismatches = 0;
    int         bytes_in = 0;
    int         bytes_out = 0;
    int         blocks_made = 0;
    int         cfg_writes = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_phase = 1'b0;
    logic       rx_hold = 1'b0;

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix_quarter(input int a, input int b, input int c, input int d);
        mix_words[b] = mix_words[b] ^ rot_left(mix_words[a] + mix_words[d], 7);
        mix_words[c] = mix_words[c] ^ rot_left(mix_words[b] + mix_words[a], 9);
        mix_words[d] = mix_words[d] ^ rot_left(mix_words[c] + mix_words[b], 13);
        mix_words[a] = mix_words[a] ^ rot_left(mix_words[d] + mix_words[c], 18);
    endfunction

    // Generates the 64 keystream bytes for the current block counter.
    function automatic void refill_keystream();
        logic [31:0] seed [16];
        logic [31:0] sum;
        seed[0]  = SIGMA0;
        seed[1]  = key_regs[REG_KEY_LOW][31:0];
        seed[2]  = key_regs[REG_KEY_LOW][63:32];
        seed[3]  = key_regs[REG_KEY_MID_LOW][31:0];
        seed[4]  = key_regs[REG_KEY_MID_LOW][63:32];
        seed[5]  = SIGMA1;
        seed[6]  = key_regs[REG_NONCE][31:0];
        seed[7]  = key_regs[REG_NONCE][63:32];
        seed[8]  = next_block_count[31:0];
        seed[9]  = next_block_count[63:32];
        seed[10] = SIGMA2;
        seed[11] = key_regs[REG_KEY_MID_HIGH][31:0];
        seed[12] = key_regs[REG_KEY_MID_HIGH][63:32];
        seed[13] = key_regs[REG_KEY_HIGH][31:0];
        seed[14] = key_regs[REG_KEY_HIGH][63:32];
        seed[15] = SIGMA3;
        for (int i = 0; i < 16; i++) mix_words[i] = seed[i];
        for (int r = 0; r < PAIRS; r++) begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(5, 9, 13, 1);
            mix_quarter(10, 14, 2, 6);
            mix_quarter(15, 3, 7, 11);
            mix_quarter(0, 1, 2, 3);
            mix_quarter(5, 6, 7, 4);
            mix_quarter(10, 11, 8, 9);
            mix_quarter(15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++) begin
            sum = mix_words[i] + seed[i];
            for (int k = 0; k < 4; k++) keystream[4 * i + k] = sum[8 * k +: 8];
        end
        blocks_made++;
    endfunction

    // Works out the cipher byte for one accepted input word and advances the stream.
    function automatic logic [7:0] cipher_byte(input t_byte_in w);
        logic [7:0] r;
        if (w.start) begin
            next_block_count = key_regs[REG_INIT_COUNTER];
            stream_pos = '0;
        end
        if (stream_pos == 0) refill_keystream();
        r = w.data ^ keystream[stream_pos];
        stream_pos = stream_pos + 6'd1;
        if (stream_pos == 0) next_block_count = next_block_count + 64'd1;
        return r;
    endfunction

    task automatic report_mismatch(input logic [7:0] got, input logic [7:0] want);
        $display("mismatch at result %0d: result_byte %02h, predicted %02h", bytes_out, got,
                 want);
        mismatches++;
    endtask

    // Driver: presents queued words on the input side with random idle cycles.
    always @(posedge i_clk) begin : drive_input
        logic taken;
        taken = i_push && !o_full;
        if (taken) begin
            expected_bytes.push_back(cipher_byte('{data: i_data_byte, start: i_message_start}));
            bytes_in++;
        end
        if (i_rst_n && (!i_push || taken)) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_push <= 1'b1;
                i_data_byte <= pending_bytes[0].data;
                i_message_start <= pending_bytes[0].start;
                void'(pending_bytes.pop_front());
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Monitor: pops result words with random stalls and checks each against the prediction.
    always @(posedge i_clk) begin
        if (i_pop && !o_empty) begin
            if (expected_bytes.size() == 0) begin
                $display("unexpected result word %02h", o_result_byte);
                mismatches++;
            end else begin
                if (o_result_byte !== expected_bytes[0])
                    report_mismatch(o_result_byte, expected_bytes[0]);
                void'(expected_bytes.pop_front());
            end
            bytes_out++;
        end
        i_pop <= i_rst_n && !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off so the queues fill and the input side stalls.
    always begin
        wait (hold_phase);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
        wait (!hold_phase);
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= REG_INIT_COUNTER) key_regs[idx] = val;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mode 0 writes all zeros, mode 1 all ones, otherwise random values.
    task automatic load_regs(input int mode);
        logic [63:0] v;
        for (int i = 0; i <= REG_INIT_COUNTER; i++) begin
            v = (mode == 0) ? 64'd0 : (mode == 1) ? '1 : rand64();
            write_reg(CFG_IDX_W'(i), v);
        end
        write_reg(REG_SPARE_A, rand64());
        write_reg(REG_SPARE_B, '1);
    endtask

    // Waits until every queued word was taken and every result checked.
    task automatic drain();
        while (pending_bytes.size() != 0 || i_push || expected_bytes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly whole messages with random content; the rest is loose words with random flags.
    task automatic queue_traffic(input int count);
        int n;
        int len;
        n = 0;
        while (n < count) begin
            if ($urandom_range(9) < 8) begin
                len = $urandom_range(1, 140);
                for (int i = 0; i < len && n < count; i++, n++)
                    pending_bytes.push_back('{data: 8'($urandom), start: (i == 0)});
            end else begin
                pending_bytes.push_back('{data: 8'($urandom), start: 1'($urandom)});
                n++;
            end
        end
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                             input int mode);
        load_regs(mode);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        queue_traffic(count);
        drain();
    endtask

    initial begin
        for (int i = 0; i < 6; i++) key_regs[i] = '0;
        next_block_count = '0;
        stream_pos = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Right after reset with no message start: the stream starts at block zero.
        pending_bytes.push_back('{data: 8'h00, start: 1'b0});
        pending_bytes.push_back('{data: 8'hff, start: 1'b0});
        pending_bytes.push_back('{data: 8'ha5, start: 1'b0});
        pending_bytes.push_back('{data: 8'h5a, start: 1'b0});
        drain();

        // A register write in the middle of a block only takes effect at the next block.
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_INIT_COUNTER, '1);
        @(negedge i_clk);
        for (int i = 0; i < 64; i++)
            pending_bytes.push_back('{data: (i % 2) ? 8'hff : 8'h00, start: 1'b0});
        // Counter at its maximum, then a message long enough to wrap it to zero.
        pending_bytes.push_back('{data: 8'hff, start: 1'b1});
        for (int i = 0; i < 70; i++)
            pending_bytes.push_back('{data: 8'($urandom), start: 1'b0});
        pending_bytes.push_back('{data: 8'h00, start: 1'b1});
        pending_bytes.push_back('{data: 8'h80, start: 1'b1});
        drain();

        run_phase(250, 0, 0, 1);
        run_phase(250, 55, 0, 2);
        run_phase(250, 0, 55, 0);
        run_phase(250, 12, 12, 2);
        run_phase(200, 55, 55, 2);

        // Input keeps offering words while the receiver holds off.
        load_regs(2);
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_phase = 1'b1;
        queue_traffic(300);
        drain();
        hold_phase = 1'b0;

        $display("covered %0d bytes in, %0d results, %0d keystream blocks, %0d register writes",
                 bytes_in, bytes_out, blocks_made, cfg_writes);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_bytes.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/s20_pkg.sv
hw/rtl/s20_fifo.sv
hw/rtl/s20_core.sv
hw/rtl/salsa20_stream_cipher.sv
bench/tb.sv
